FILE: design/b2da_pkg.sv
// Shared constants and types for the binary to decimal ASCII converter.
// No dependencies; used by b2da_cell, b2da_chain and binary_to_decimal_ascii_top.
`default_nettype none

package b2da_pkg;

  // Default width of the binary operand
  localparam int VALUE_WIDTH_DEFAULT = 64;

  // Width of one BCD digit held by a cell
  localparam int DIGIT_W = 4;

  // Width of the ASCII character port
  localparam int CHAR_W = 6;

  // ASCII code of '0', trimmed to the character port width
  localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

  // Digits that need the add-three correction before a shift
  localparam logic [DIGIT_W-1:0] BCD_ADJ_LIMIT = 4'd5;
  localparam logic [DIGIT_W-1:0] BCD_ADJ_ADD   = 4'd3;

  // Control that the sequencer sends down the digit chain
  typedef struct packed {
    logic clear;  // zero every digit
    logic conv;   // correct and shift one binary bit in
    logic emit;   // move every digit one cell toward the top
  } chain_ctrl_t;

endpackage

`default_nettype wire

FILE: design/b2da_cell.sv
// One BCD digit cell of the shift-and-add-three chain.
// Depends on b2da_pkg for the digit width and the control struct.
`default_nettype none

module b2da_cell (
  input  wire                           clk,
  input  wire b2da_pkg::chain_ctrl_t    ctrl,
  input  wire                           shift_in,
  input  wire [b2da_pkg::DIGIT_W-1:0]   digit_in,
  output logic                          shift_out,
  output logic [b2da_pkg::DIGIT_W-1:0]  digit
);

  logic [b2da_pkg::DIGIT_W-1:0] corr;

  // Add three to digits of five or more so the shift carries correctly
  always_comb begin
    if (digit >= b2da_pkg::BCD_ADJ_LIMIT) begin
      corr = digit + b2da_pkg::BCD_ADJ_ADD;
    end else begin
      corr = digit;
    end
    shift_out = corr[b2da_pkg::DIGIT_W-1];
  end

  // Clear, shift a bit in, or take the lower neighbor's digit
  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      digit <= '0;
    end else if (ctrl.conv) begin
      digit <= {corr[b2da_pkg::DIGIT_W-2:0], shift_in};
    end else if (ctrl.emit) begin
      digit <= digit_in;
    end
  end

endmodule

`default_nettype wire

FILE: design/b2da_chain.sv
// Row of BCD digit cells, least significant cell at index zero.
// Depends on b2da_pkg and b2da_cell.
`default_nettype none

module b2da_chain #(
  parameter int NUM_DIGITS = 20
) (
  input  wire                           clk,
  input  wire b2da_pkg::chain_ctrl_t    ctrl,
  input  wire                           shift_in,
  output logic [b2da_pkg::DIGIT_W-1:0]  top_digit,
  output logic                          carry_out
);

  logic                          carry [NUM_DIGITS+1];
  logic [b2da_pkg::DIGIT_W-1:0]  dig   [NUM_DIGITS];

  assign carry[0] = shift_in;

  // Link each cell to its lower neighbor
  for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
    logic [b2da_pkg::DIGIT_W-1:0] lower;
    if (i == 0) begin : g_bottom
      assign lower = '0;
    end else begin : g_upper
      assign lower = dig[i-1];
    end
    b2da_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .shift_in  (carry[i]),
      .digit_in  (lower),
      .shift_out (carry[i+1]),
      .digit     (dig[i])
    );
  end

  assign top_digit = dig[NUM_DIGITS-1];
  assign carry_out = carry[NUM_DIGITS];

endmodule

`default_nettype wire

FILE: design/binary_to_decimal_ascii_top.sv
// Top level of the binary to decimal ASCII converter: sequencer and output register.
// Depends on b2da_pkg and b2da_chain.
`default_nettype none

// Converts one unsigned VALUE_WIDTH-bit number per transaction into its decimal
// digits as ASCII characters, most significant first, without leading zeros
// (zero gives a single '0'); last_digit marks the final character. Pulse start
// while busy is low to hand over value. Each character appears on digit_char
// and last_digit for exactly one cycle with strobe high, and the receiver
// must take it then, since the block cannot be held off. A transaction keeps
// busy high while each binary bit is shifted through the row of BCD digit
// cells, and then while every digit cell is shifted out of the top cell; the
// last character is shown in the first cycle with busy low, so a new value
// can be taken in that same cycle.
module binary_to_decimal_ascii_top #(
  parameter int VALUE_WIDTH = b2da_pkg::VALUE_WIDTH_DEFAULT
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          start,
  output logic                         busy,
  input  wire [VALUE_WIDTH-1:0]        value,
  output logic [b2da_pkg::CHAR_W-1:0]  digit_char,
  output logic                         last_digit,
  output logic                         strobe
);

  // Decimal digits of 2^VALUE_WIDTH - 1
  localparam int NUM_DIGITS = (VALUE_WIDTH * 30103) / 100000 + 1;
  localparam int CNT_W      = $clog2(VALUE_WIDTH);
  localparam logic [CNT_W-1:0] CONV_LAST = CNT_W'(VALUE_WIDTH - 1);
  localparam logic [CNT_W-1:0] EMIT_LAST = CNT_W'(NUM_DIGITS - 1);

  typedef enum logic [1:0] {
    IDLE,
    CONV,
    EMIT
  } state_t;

  state_t                        state;
  logic [CNT_W-1:0]              cnt;
  logic [VALUE_WIDTH-1:0]        shreg;
  logic                          started;
  b2da_pkg::chain_ctrl_t         ctrl;
  logic [b2da_pkg::DIGIT_W-1:0]  top_digit;
  logic                          carry_out;
  logic                          accept;
  logic                          is_last;
  logic                          nonzero;

  assign busy    = (state != IDLE);
  assign accept  = start && !busy;
  assign is_last = (cnt == EMIT_LAST);
  assign nonzero = (top_digit != '0);

  // Drive the digit chain from the sequencer state
  always_comb begin
    ctrl.clear = accept;
    ctrl.conv  = (state == CONV);
    ctrl.emit  = (state == EMIT);
  end

  b2da_chain #(
    .NUM_DIGITS (NUM_DIGITS)
  ) u_chain (
    .clk       (clk),
    .ctrl      (ctrl),
    .shift_in  (shreg[VALUE_WIDTH-1]),
    .top_digit (top_digit),
    .carry_out (carry_out)
  );

  // Sequence the transaction: load, convert bit by bit, emit digit by digit
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= IDLE;
      cnt     <= '0;
      started <= 1'b0;
      strobe  <= 1'b0;
    end else begin
      strobe <= 1'b0;
      unique case (state)
        IDLE: begin
          if (accept) begin
            state   <= CONV;
            cnt     <= '0;
            started <= 1'b0;
          end
        end
        CONV: begin
          if (cnt == CONV_LAST) begin
            state <= EMIT;
            cnt   <= '0;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        EMIT: begin
          // Drop leading zeros, but always show the final digit
          strobe  <= nonzero || started || is_last;
          started <= started || nonzero;
          if (is_last) begin
            state <= IDLE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  // Hold the operand and shift it out msb first; register the character
  always_ff @(posedge clk) begin
    if (accept) begin
      shreg <= value;
    end else if (state == CONV) begin
      shreg <= {shreg[VALUE_WIDTH-2:0], 1'b0};
    end
    digit_char <= b2da_pkg::ASCII_ZERO + {{(b2da_pkg::CHAR_W-b2da_pkg::DIGIT_W){1'b0}}, top_digit};
    last_digit <= is_last;
  end

  // The chain is sized so no carry ever leaves the top cell
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    ctrl.conv |-> !carry_out)
    else $error("decimal digit chain overflowed");

  // Once a character is shown, every following one is shown up to the last
  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    strobe && !last_digit |=> strobe)
    else $error("gap inside a digit run");

  // Nothing follows the final character of a run
  a_run_end: assert property (@(posedge clk) disable iff (rst)
    strobe && last_digit |=> !strobe)
    else $error("character after final digit");

  // An accepted transaction keeps the block busy
  a_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy && !strobe)
    else $error("busy not raised after start");

endmodule

`default_nettype wire
